[sv/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue package
// Shared constants, codes and types for the timer queue modules.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int NUM_PROCS  = 16;
    localparam int DELAY_BITS = 16;
    localparam int SLOT_W     = $clog2(NUM_PROCS);
    localparam int CNT_W      = $clog2(NUM_PROCS + 1);
    localparam int PID_W      = 4;
    localparam int SECS_W     = 16;
    localparam int TPS_W      = 10;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(60);

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic EV_WAKE = 1'b0;
    localparam logic EV_ACK  = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_DUP = 1'b1;

    typedef struct packed {
        logic [DELAY_BITS-1:0] diff;
        logic                  lt;
        logic                  eq;
    } t_alu_res;

    typedef struct packed {
        logic              has_next;
        logic [SLOT_W-1:0] next_slot;
    } t_link;

endpackage

[sv/dltq_alu.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue subtract and compare unit
// Shared subtractor with less-than and equality flags for all delta updates.
// ----------------------------------------------------------------------------
module dltq_alu (
    input  logic [dltq_pkg::DELAY_BITS-1:0] i_a,
    input  logic [dltq_pkg::DELAY_BITS-1:0] i_b,
    output dltq_pkg::t_alu_res              o_res
);
    import dltq_pkg::*;

    always_comb begin
        o_res.diff = i_a - i_b;
        o_res.lt   = (i_a < i_b);
        o_res.eq   = (i_a == i_b);
    end

endmodule

[sv/dltq_seq.sv]
// ----------------------------------------------------------------------------
// Delta list timer queue sequencer
// Walks and updates the delta list in its memories one entry at a time and
// holds the result register.
// ----------------------------------------------------------------------------
module dltq_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [dltq_pkg::TPS_W-1:0]      i_tps,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [dltq_pkg::PID_W-1:0]      i_proc_id,
    input  logic [dltq_pkg::SECS_W-1:0]     i_delay_seconds,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_event_kind,
    output logic [dltq_pkg::PID_W-1:0]      o_woken_id,
    output logic                            o_status,
    output logic                            o_last
);
    import dltq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TK_RD,
        S_TK_DEC,
        S_POP,
        S_POP_RD,
        S_POP_CHK,
        S_EMIT_LAST,
        S_INS_RD,
        S_INS_CMP,
        S_INS_RDF,
        S_INS_FIX,
        S_INS_LINK,
        S_INS_PREV,
        S_ACK
    } t_state;

    logic [DELAY_BITS-1:0] delta_mem [NUM_PROCS];
    t_link                 link_mem  [NUM_PROCS];

    t_state                r_state, n_state;
    logic [TPS_W-1:0]      r_count, n_count;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic                  r_nonempty, n_nonempty;
    logic [NUM_PROCS-1:0]  r_queued, n_queued;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic                  r_cur_ok, n_cur_ok;
    logic [SLOT_W-1:0]     r_prev, n_prev;
    logic                  r_prev_ok, n_prev_ok;
    logic [SLOT_W-1:0]     r_pend, n_pend;
    logic [DELAY_BITS-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]      r_steps, n_steps;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic                  r_ack_status, n_ack_status;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_kind, n_out_kind;
    logic [PID_W-1:0]      r_out_id, n_out_id;
    logic                  r_out_status, n_out_status;
    logic                  r_out_last, n_out_last;

    logic [DELAY_BITS-1:0] r_delta_q;
    t_link                 r_link_q;

    logic                  dmem_we;
    logic [SLOT_W-1:0]     dmem_addr;
    logic [DELAY_BITS-1:0] dmem_wdata;
    logic                  lmem_we;
    logic [SLOT_W-1:0]     lmem_addr;
    t_link                 lmem_wdata;

    logic [DELAY_BITS-1:0] alu_a, alu_b;
    t_alu_res              alu_res;

    logic                  out_free;
    logic                  in_acc;
    logic [TPS_W:0]        next_count;
    logic                  pid_bad;
    logic [SLOT_W-1:0]     in_slot;
    logic [SLOT_W-1:0]     pid_slot;
    logic [CNT_W-1:0]      steps_inc;

    dltq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign out_free   = !r_out_valid || !i_stall;
    assign in_acc     = i_valid && (r_state == S_IDLE);
    assign next_count = {1'b0, r_count} + (TPS_W+1)'(1);
    assign pid_bad    = ({1'b0, i_proc_id} >= (PID_W+1)'(NUM_PROCS));
    assign in_slot    = SLOT_W'(i_proc_id);
    assign pid_slot   = SLOT_W'(r_pid);
    assign steps_inc  = r_steps + CNT_W'(1);

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_woken_id   = r_out_id;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_nonempty   = r_nonempty;
        n_queued     = r_queued;
        n_cur        = r_cur;
        n_cur_ok     = r_cur_ok;
        n_prev       = r_prev;
        n_prev_ok    = r_prev_ok;
        n_pend       = r_pend;
        n_rem        = r_rem;
        n_steps      = r_steps;
        n_pid        = r_pid;
        n_ack_status = r_ack_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        dmem_we      = 1'b0;
        dmem_addr    = r_cur;
        dmem_wdata   = r_rem;
        lmem_we      = 1'b0;
        lmem_addr    = r_cur;
        lmem_wdata   = '0;
        alu_a        = r_rem;
        alu_b        = r_delta_q;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_INSERT) begin
                        n_pid = i_proc_id;
                        if (pid_bad) begin
                            n_ack_status = ST_DUP;
                            n_state      = S_ACK;
                        end else if (r_queued[in_slot]) begin
                            n_ack_status = ST_DUP;
                            n_state      = S_ACK;
                        end else begin
                            n_ack_status = ST_OK;
                            n_rem        = DELAY_BITS'(i_delay_seconds);
                            n_cur        = r_head;
                            n_cur_ok     = r_nonempty;
                            n_prev_ok    = 1'b0;
                            n_steps      = '0;
                            n_state      = r_nonempty ? S_INS_RD : S_INS_LINK;
                        end
                    end else begin
                        if (next_count < {1'b0, i_tps}) begin
                            n_count = TPS_W'(next_count);
                        end else begin
                            n_count = '0;
                            if (r_nonempty) begin
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = S_TK_RD;
                            end
                        end
                    end
                end
            end
            S_TK_RD: begin
                n_state = S_TK_DEC;
            end
            S_TK_DEC: begin
                alu_a      = r_delta_q;
                alu_b      = DELAY_BITS'(1);
                dmem_we    = 1'b1;
                dmem_wdata = alu_res.lt ? '0 : alu_res.diff;
                n_state    = (alu_res.lt || alu_res.eq) ? S_POP : S_IDLE;
            end
            S_POP: begin
                n_queued[r_cur] = 1'b0;
                lmem_we         = 1'b1;
                n_nonempty      = r_link_q.has_next;
                n_head          = r_link_q.has_next ? r_link_q.next_slot : '0;
                n_pend          = r_cur;
                n_steps         = steps_inc;
                if (r_link_q.has_next && (steps_inc < CNT_W'(NUM_PROCS))) begin
                    n_cur   = r_link_q.next_slot;
                    n_state = S_POP_RD;
                end else begin
                    n_state = S_EMIT_LAST;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                alu_a = r_delta_q;
                alu_b = '0;
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = EV_WAKE;
                    n_out_id     = PID_W'(r_pend);
                    n_out_status = ST_OK;
                    n_out_last   = !alu_res.eq;
                    n_state      = alu_res.eq ? S_POP : S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = EV_WAKE;
                    n_out_id     = PID_W'(r_pend);
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (alu_res.lt) begin
                    n_state = S_INS_FIX;
                end else begin
                    n_rem     = alu_res.diff;
                    n_prev    = r_cur;
                    n_prev_ok = 1'b1;
                    n_cur_ok  = r_link_q.has_next;
                    n_cur     = r_link_q.next_slot;
                    n_steps   = steps_inc;
                    if (!r_link_q.has_next) begin
                        n_state = S_INS_LINK;
                    end else if (steps_inc < CNT_W'(NUM_PROCS)) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_INS_RDF;
                    end
                end
            end
            S_INS_RDF: begin
                n_state = S_INS_FIX;
            end
            S_INS_FIX: begin
                alu_a      = r_delta_q;
                alu_b      = r_rem;
                dmem_we    = 1'b1;
                dmem_wdata = alu_res.diff;
                n_state    = S_INS_LINK;
            end
            S_INS_LINK: begin
                dmem_we              = 1'b1;
                dmem_addr            = pid_slot;
                dmem_wdata           = r_rem;
                lmem_we              = 1'b1;
                lmem_addr            = pid_slot;
                lmem_wdata.has_next  = r_cur_ok;
                lmem_wdata.next_slot = r_cur_ok ? r_cur : '0;
                n_queued[pid_slot]   = 1'b1;
                if (r_prev_ok) begin
                    n_state = S_INS_PREV;
                end else begin
                    n_head     = pid_slot;
                    n_nonempty = 1'b1;
                    n_state    = S_ACK;
                end
            end
            S_INS_PREV: begin
                lmem_we              = 1'b1;
                lmem_addr            = r_prev;
                lmem_wdata.has_next  = 1'b1;
                lmem_wdata.next_slot = pid_slot;
                n_state              = S_ACK;
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = EV_ACK;
                    n_out_id     = r_pid;
                    n_out_status = r_ack_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_queued    <= n_queued;
            r_out_valid <= n_out_valid;
        end
        r_cur        <= n_cur;
        r_cur_ok     <= n_cur_ok;
        r_prev       <= n_prev;
        r_prev_ok    <= n_prev_ok;
        r_pend       <= n_pend;
        r_rem        <= n_rem;
        r_steps      <= n_steps;
        r_pid        <= n_pid;
        r_ack_status <= n_ack_status;
        r_out_kind   <= n_out_kind;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            delta_mem[dmem_addr] <= dmem_wdata;
        end
        if (lmem_we) begin
            link_mem[lmem_addr] <= lmem_wdata;
        end
        r_delta_q <= delta_mem[r_cur];
        r_link_q  <= link_mem[r_cur];
    end

endmodule

[sv/delta_list_timer_queue.sv]
// A tick inside a second only advances the divider; a tick at a second boundary
// decrements the head delta of a non-empty list and wakes every process whose delta
// reaches zero. An insert passes the entries that expire no later than it and links in
// at the list end, before a larger entry or into an empty list; an ignored insert is
// acknowledged with the duplicate status. One transaction at a time.
// Reset is synchronous: it empties the list and the divider and sets the rate to 60.
// ----------------------------------------------------------------------------
// Delta list timer queue
// Sleep timer queue kept as a delta list sorted by expiry, one slot per
// process, with a configurable sub-second tick divider.
// ----------------------------------------------------------------------------
module delta_list_timer_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [dltq_pkg::TPS_W-1:0]      i_cfg_wr_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [dltq_pkg::PID_W-1:0]      i_proc_id,
    input  logic [dltq_pkg::SECS_W-1:0]     i_delay_seconds,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_event_kind,
    output logic [dltq_pkg::PID_W-1:0]      o_woken_id,
    output logic                            o_status,
    output logic                            o_last
);
    import dltq_pkg::*;

    logic [TPS_W-1:0] r_tps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_tps <= i_cfg_wr_data;
        end
    end

    dltq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tps           (r_tps),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_proc_id       (i_proc_id),
        .i_delay_seconds (i_delay_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_woken_id      (o_woken_id),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule
